// ===== sv/ipv4p_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4p_pkg
// Codes and character classes shared by the dotted-address parser and its
// checker.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

	localparam int ChW   = 8;
	localparam int AddrW = 32;

	// Parser phase codes.
	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_ZERO   = 3'd1;
	localparam logic [2:0] PH_DIGITS = 3'd2;
	localparam logic [2:0] PH_DONE   = 3'd3;
	localparam logic [2:0] PH_FAIL   = 3'd4;

	// Radix codes.
	localparam logic [1:0] RX_DEC = 2'd0;
	localparam logic [1:0] RX_OCT = 2'd1;
	localparam logic [1:0] RX_HEX = 2'd2;

	// Characters with a meaning of their own.
	localparam logic [ChW-1:0] CH_NUL  = 8'h00;
	localparam logic [ChW-1:0] CH_ZERO = 8'h30;
	localparam logic [ChW-1:0] CH_DOT  = 8'h2e;
	localparam logic [ChW-1:0] CH_LX   = 8'h78;
	localparam logic [ChW-1:0] CH_UX   = 8'h58;

	// Range limits of the last part, by the number of parts before it.
	localparam logic [AddrW-1:0] LIM_24 = 32'h00ff_ffff;
	localparam logic [AddrW-1:0] LIM_16 = 32'h0000_ffff;
	localparam logic [AddrW-1:0] LIM_8  = 32'h0000_00ff;

	function automatic logic is_dec(input logic [ChW-1:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_space(input logic [ChW-1:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
	endfunction

endpackage

// ===== sv/ipv4_dotted_address_parser_core.sv =====
// ----------------------------------------------------------------------------
// ipv4_dotted_address_parser_core
// Streaming parser of dotted IPv4 address text, one character per item,
// following the classic BSD address-text rules. A NUL character ends the text
// and gives one result: a valid flag and the 32-bit address.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------
//  in      | in_valid / in_stall  | ch [7:0]
//  out     | out_valid / out_stall| valid_res, address [31:0]
//
// One character is taken each cycle while no stalled NUL waits in the input
// register. A character passes through the input register, and the parse step
// between that register and the result register updates the state. A NUL
// loads the result register as it leaves the input register.
// Reset clears the valid bits of the input and result registers and the parse
// state.
// Only a NUL waits in the input register while an earlier result is stalled;
// other characters move on whatever the output side does.
// ----------------------------------------------------------------------------
module ipv4_dotted_address_parser_core
	import ipv4p_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [ChW-1:0]   ch,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             valid_res,
	output logic [AddrW-1:0] address
);

	logic             valid_s1;
	logic [ChW-1:0]   ch_s1;

	logic [2:0]       phase_q, phase_d;
	logic [AddrW-1:0] value_q, value_d;
	logic [1:0]       radix_q, radix_d;
	logic [1:0]       count_q, count_d;
	logic [AddrW-1:0] saved_q [3];
	logic             save_en;

	logic             res_valid_q;
	logic             res_ok_q;
	logic [AddrW-1:0] res_addr_q;

	logic             fire;
	logic             is_nul;
	logic             asm_ok;
	logic [AddrW-1:0] asm_addr;
	logic             end_ok;
	logic [AddrW-1:0] end_addr;
	logic [AddrW-1:0] mul_val;
	logic [3:0]       hex_nib;
	logic             hex_lo, hex_up;
	logic [1:0]       eff_radix;

	assign is_nul   = (ch_s1 == CH_NUL);
	// A NUL needs room in the result register; any other character always moves.
	assign fire     = valid_s1 && (!is_nul || !res_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1 <= ch;
		end
	end

	// Combine the saved parts with the running value.
	always_comb begin
		asm_ok   = 1'b1;
		asm_addr = value_q;
		case (count_q)
			2'd0: begin
				asm_addr = value_q;
			end
			2'd1: begin
				asm_ok   = (value_q <= LIM_24) && (saved_q[0] <= LIM_8);
				asm_addr = value_q | (saved_q[0] << 24);
			end
			2'd2: begin
				asm_ok   = (value_q <= LIM_16) && (saved_q[0] <= LIM_8)
				           && (saved_q[1] <= LIM_8);
				asm_addr = value_q | (saved_q[0] << 24) | (saved_q[1] << 16);
			end
			default: begin
				asm_ok   = (value_q <= LIM_8) && (saved_q[0] <= LIM_8)
				           && (saved_q[1] <= LIM_8) && (saved_q[2] <= LIM_8);
				asm_addr = value_q | (saved_q[0] << 24) | (saved_q[1] << 16)
				           | (saved_q[2] << 8);
			end
		endcase
	end

	// Result of a NUL for the present state.
	always_comb begin
		end_ok   = 1'b0;
		end_addr = '0;
		if ((phase_q == PH_ZERO) || (phase_q == PH_DIGITS)) begin
			end_ok   = asm_ok;
			end_addr = asm_ok ? asm_addr : '0;
		end else if (phase_q == PH_DONE) begin
			end_ok   = 1'b1;
			end_addr = value_q;
		end
	end

	// A leading zero without an x goes on as an octal digit run.
	assign eff_radix = radix_q;
	assign hex_lo    = (ch_s1 >= 8'h61) && (ch_s1 <= 8'h66);
	assign hex_up    = (ch_s1 >= 8'h41) && (ch_s1 <= 8'h46);
	assign hex_nib   = hex_lo ? 4'(ch_s1 - 8'h57) : 4'(ch_s1 - 8'h37);

	always_comb begin
		case (eff_radix)
			RX_HEX:  mul_val = value_q << 4;
			RX_OCT:  mul_val = value_q << 3;
			default: mul_val = (value_q << 3) + (value_q << 1);
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		value_d = value_q;
		radix_d = radix_q;
		count_d = count_q;
		save_en = 1'b0;
		if (is_nul) begin
			phase_d = PH_START;
			value_d = '0;
			radix_d = RX_DEC;
			count_d = '0;
		end else begin
			unique case (phase_q)
				PH_START: begin
					if (!is_dec(ch_s1)) begin
						phase_d = PH_FAIL;
					end else if (ch_s1 == CH_ZERO) begin
						value_d = '0;
						radix_d = RX_OCT;
						phase_d = PH_ZERO;
					end else begin
						value_d = AddrW'(ch_s1 - CH_ZERO);
						radix_d = RX_DEC;
						phase_d = PH_DIGITS;
					end
				end
				PH_DONE, PH_FAIL: begin
				end
				PH_ZERO, PH_DIGITS: begin
					if ((phase_q == PH_ZERO) && ((ch_s1 == CH_LX) || (ch_s1 == CH_UX))) begin
						radix_d = RX_HEX;
						phase_d = PH_DIGITS;
					end else begin
						phase_d = PH_DIGITS;
						if (is_dec(ch_s1)) begin
							value_d = mul_val + AddrW'(ch_s1 - CH_ZERO);
						end else if ((radix_q == RX_HEX) && (hex_lo || hex_up)) begin
							value_d = mul_val | AddrW'(hex_nib);
						end else if (ch_s1 == CH_DOT) begin
							if (count_q == 2'd3) begin
								phase_d = PH_FAIL;
							end else begin
								save_en = 1'b1;
								count_d = count_q + 2'd1;
								value_d = '0;
								radix_d = RX_DEC;
								phase_d = PH_START;
							end
						end else if (is_space(ch_s1)) begin
							if (asm_ok) begin
								value_d = asm_addr;
								phase_d = PH_DONE;
							end else begin
								phase_d = PH_FAIL;
							end
						end else begin
							phase_d = PH_FAIL;
						end
					end
				end
				default: begin
					phase_d = PH_FAIL;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			value_q    <= '0;
			radix_q    <= RX_DEC;
			count_q    <= '0;
			saved_q[0] <= '0;
			saved_q[1] <= '0;
			saved_q[2] <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			value_q <= value_d;
			radix_q <= radix_d;
			count_q <= count_d;
			if (is_nul) begin
				saved_q[0] <= '0;
				saved_q[1] <= '0;
				saved_q[2] <= '0;
			end else if (save_en) begin
				saved_q[count_q] <= value_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && is_nul) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_nul) begin
			res_ok_q   <= end_ok;
			res_addr_q <= end_addr;
		end
	end

	assign out_valid = res_valid_q;
	assign valid_res = res_ok_q;
	assign address   = res_addr_q;

endmodule

// ===== sv/ipv4p_checker.sv =====
// ----------------------------------------------------------------------------
// ipv4p_checker
// Port-level checks of the dotted-address parser, bound to its top level.
// ----------------------------------------------------------------------------
module ipv4p_checker
	import ipv4p_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic [ChW-1:0]   ch,
	input logic             out_valid,
	input logic             out_stall,
	input logic             valid_res,
	input logic [AddrW-1:0] address
);

	// A stalled result holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(valid_res) && $stable(address))
	else $error("stalled result changed");

	// A failed parse reports a zero address.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> address == '0)
	else $error("failed result with nonzero address");

	// The input side only waits behind a stalled result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
	else $error("input stalled without a stalled result");

	// A fresh result follows the acceptance of a NUL.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && (ch == CH_NUL), 2))
	else $error("result without a terminating NUL");

endmodule

bind ipv4_dotted_address_parser_core ipv4p_checker u_ipv4p_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.ch        (ch),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.valid_res (valid_res),
	.address   (address)
);

// ===== tb/tb_ipv4_dotted_address_parser_core.sv =====
// ----------------------------------------------------------------------------
// tb_ipv4_dotted_address_parser_core
// Sends address text to the dotted-address parser one character per item and
// predicts the valid flag and address that each NUL must produce. The text
// is a short directed set, then mostly well-formed addresses with random
// parts and radixes, with broken strings and raw noise mixed in. The input
// side idles and the result side stalls at random.
// ----------------------------------------------------------------------------
module tb_ipv4_dotted_address_parser_core;
	timeunit 1ns;
	timeprecision 1ps;

	import ipv4p_pkg::*;

	localparam int CycleLimit  = 200000;
	localparam int RandomChars = 750;

	localparam logic [ChW-1:0] CH_TAB   = 8'h09;
	localparam logic [ChW-1:0] CH_CR    = 8'h0d;
	localparam logic [ChW-1:0] CH_SPACE = 8'h20;
	localparam logic [ChW-1:0] CH_LA    = 8'h61;
	localparam logic [ChW-1:0] CH_LF    = 8'h66;
	localparam logic [ChW-1:0] CH_UA    = 8'h41;
	localparam logic [ChW-1:0] CH_UF    = 8'h46;

	typedef struct packed {
		logic             ok;
		logic [AddrW-1:0] addr;
	} addr_result_t;

	class address_scoreboard;
		logic [2:0]       phase;
		logic [AddrW-1:0] value;
		logic [1:0]       radix;
		logic [1:0]       part_count;
		logic [AddrW-1:0] saved [3];
		addr_result_t     pending_addrs[$];
		int               mismatches;

		function new();
			mismatches = 0;
			clear();
		endfunction

		function void clear();
			phase = PH_START;
			value = '0;
			radix = RX_DEC;
			part_count = '0;
			foreach (saved[i]) saved[i] = '0;
		endfunction

		function bit is_digit(logic [ChW-1:0] c);
			return c >= CH_ZERO && c <= CH_ZERO + 8'd9;
		endfunction

		function bit is_blank(logic [ChW-1:0] c);
			return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
		endfunction

		// Joins the parts closed by a dot with the running one.
		function bit combine(output logic [AddrW-1:0] addr);
			addr = '0;
			case (part_count)
				2'd0: begin
					addr = value;
					return 1'b1;
				end
				2'd1: begin
					if (value > LIM_24 || saved[0] > LIM_8) return 1'b0;
					addr = value | (saved[0] << 24);
					return 1'b1;
				end
				2'd2: begin
					if (value > LIM_16 || saved[0] > LIM_8 || saved[1] > LIM_8) return 1'b0;
					addr = value | (saved[0] << 24) | (saved[1] << 16);
					return 1'b1;
				end
				default: begin
					if (value > LIM_8 || saved[0] > LIM_8 || saved[1] > LIM_8 ||
							saved[2] > LIM_8) return 1'b0;
					addr = value | (saved[0] << 24) | (saved[1] << 16) | (saved[2] << 8);
					return 1'b1;
				end
			endcase
		endfunction

		function void take_char(logic [ChW-1:0] c);
			logic [AddrW-1:0] addr;
			logic [AddrW-1:0] mul;
			bit ok;
			addr = '0;
			ok = 1'b0;
			if (c == CH_NUL) begin
				if (phase == PH_ZERO || phase == PH_DIGITS) begin
					ok = combine(addr);
				end else if (phase == PH_DONE) begin
					ok = 1'b1;
					addr = value;
				end
				if (!ok) addr = '0;
				pending_addrs.push_back('{ok, addr});
				clear();
				return;
			end
			case (phase)
				PH_START: begin
					if (!is_digit(c)) begin
						phase = PH_FAIL;
					end else if (c == CH_ZERO) begin
						value = '0;
						radix = RX_OCT;
						phase = PH_ZERO;
					end else begin
						value = AddrW'(c - CH_ZERO);
						radix = RX_DEC;
						phase = PH_DIGITS;
					end
					return;
				end
				PH_ZERO: begin
					phase = PH_DIGITS;
					if (c == CH_LX || c == CH_UX) begin
						radix = RX_HEX;
						return;
					end
				end
				PH_DIGITS: ;
				default: return;
			endcase
			if (is_digit(c)) begin
				mul = (radix == RX_HEX) ? 32'd16 : (radix == RX_OCT) ? 32'd8 : 32'd10;
				value = value * mul + AddrW'(c - CH_ZERO);
			end else if (radix == RX_HEX && c >= CH_LA && c <= CH_LF) begin
				value = {value[AddrW-5:0], 4'(c - CH_LA + 8'd10)};
			end else if (radix == RX_HEX && c >= CH_UA && c <= CH_UF) begin
				value = {value[AddrW-5:0], 4'(c - CH_UA + 8'd10)};
			end else if (c == CH_DOT) begin
				if (part_count == 2'd3) begin
					phase = PH_FAIL;
				end else begin
					saved[part_count] = value;
					part_count = part_count + 2'd1;
					value = '0;
					radix = RX_DEC;
					phase = PH_START;
				end
			end else if (is_blank(c)) begin
				if (combine(addr)) begin
					value = addr;
					phase = PH_DONE;
				end else begin
					phase = PH_FAIL;
				end
			end else begin
				phase = PH_FAIL;
			end
		endfunction

		function void flag(string what, logic [AddrW-1:0] want, logic [AddrW-1:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
		endfunction

		function void check_address(logic got_ok, logic [AddrW-1:0] got_addr);
			addr_result_t want;
			if (pending_addrs.size() == 0) begin
				flag("unexpected result", '0, got_addr);
				return;
			end
			want = pending_addrs.pop_front();
			if (got_ok !== want.ok) flag("valid_res", AddrW'(want.ok), AddrW'(got_ok));
			if (got_addr !== want.addr) flag("address", want.addr, got_addr);
		endfunction

		function int outstanding();
			return pending_addrs.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [ChW-1:0]   ch;
	logic             out_valid;
	logic             out_stall;
	logic             valid_res;
	logic [AddrW-1:0] address;

	address_scoreboard sb = new;
	logic [ChW-1:0]    text_q[$];
	bit                quiet = 1'b0;
	int                sent_chars = 0;
	int                cycle_count = 0;

	ipv4_dotted_address_parser_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ch        (ch),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.valid_res (valid_res),
		.address   (address)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("tb_ipv4_dotted_address_parser_core: errors");
			$finish;
		end
	end

	function automatic void push_digit(int lo);
		text_q.push_back(CH_ZERO + 8'($urandom_range(lo, 9)));
	endfunction

	function automatic void push_part(logic [AddrW-1:0] v, logic [1:0] rx);
		string s;
		logic [ChW-1:0] b;
		case (rx)
			RX_OCT: s = $sformatf("0%0o", v);
			RX_HEX: begin
				s = $sformatf("%s%0h", $urandom_range(0, 1) ? "0x" : "0X", v);
				// A bare prefix counts as a zero part.
				if (v == 0 && $urandom_range(0, 1)) s = s.substr(0, 1);
			end
			default: s = $sformatf("%0d", v);
		endcase
		for (int i = 0; i < s.len(); i++) begin
			b = s[i];
			if (rx == RX_HEX && i > 1 && b >= CH_LA && b <= CH_LF && $urandom_range(0, 1))
				b = b - (CH_LA - CH_UA);
			if (rx == RX_OCT && i > 0 && $urandom_range(0, 7) == 0)
				b = CH_ZERO + 8'($urandom_range(8, 9));
			text_q.push_back(b);
		end
	endfunction

	// Builds one NUL-terminated string: mostly well-formed addresses, some
	// with a blank and trailing junk, some broken, and a share of raw noise.
	function automatic void build_text();
		int kind;
		int nparts;
		int idx;
		logic [AddrW-1:0] v;
		logic [AddrW-1:0] lim;
		text_q.delete();
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(0, 8)) text_q.push_back(8'($urandom_range(1, 255)));
			text_q.push_back(CH_NUL);
			return;
		end
		nparts = $urandom_range(1, 4);
		for (int p = 0; p < nparts; p++) begin
			if (p < nparts - 1) lim = LIM_8;
			else case (nparts)
				1: lim = '1;
				2: lim = LIM_24;
				3: lim = LIM_16;
				default: lim = LIM_8;
			endcase
			case ($urandom_range(0, 9))
				0: v = $urandom;
				1: v = lim;
				2: v = '0;
				default: v = $urandom_range(0, lim);
			endcase
			if ($urandom_range(0, 15) == 0) begin
				// Long decimal run that can wrap the part value.
				push_digit(1);
				repeat ($urandom_range(9, 13)) push_digit(0);
			end else begin
				push_part(v, 2'($urandom_range(0, 2)));
			end
			if (p < nparts - 1) text_q.push_back(CH_DOT);
		end
		if (kind == 3) begin
			text_q.push_back(CH_DOT);
			push_digit(0);
		end
		if ($urandom_range(0, 3) == 0) begin
			idx = $urandom_range(0, 5);
			text_q.push_back(idx == 5 ? CH_SPACE : CH_TAB + 8'(idx));
			repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(1, 255)));
		end
		if (kind <= 2) begin
			idx = $urandom_range(0, text_q.size() - 1);
			if ($urandom_range(0, 1)) text_q[idx] = 8'($urandom_range(1, 255));
			else text_q.insert(idx, 8'($urandom_range(1, 255)));
		end
		text_q.push_back(CH_NUL);
	endfunction

	function automatic void load(string s);
		text_q.delete();
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
		text_q.push_back(CH_NUL);
	endfunction

	task automatic send_queue();
		int gap;
		foreach (text_q[i]) begin
			gap = quiet ? 0 : $urandom_range(0, 10);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			@(negedge clk);
			in_valid <= 1'b1;
			ch <= text_q[i];
			@(posedge clk);
			while (in_stall) @(posedge clk);
			sb.take_char(text_q[i]);
			sent_chars++;
		end
	endtask

	task automatic send_text(string s);
		load(s);
		send_queue();
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	// Result side: a fresh stall length is drawn after every accepted item.
	initial begin
		int hold;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				sb.check_address(valid_res, address);
				hold = quiet ? 0 : $urandom_range(0, 10);
			end
			@(negedge clk);
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int strings;
		arst_n = 1'b0;
		in_valid = 1'b0;
		ch = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_text("");
		send_text("0x");
		send_text("1.2.3.4.5");
		load("0XfF.1 z");
		text_q.insert(text_q.size() - 1, 8'hff);
		send_queue();
		send_text("089");
		send_text("9g");
		send_text("256.1");
		send_text("255.255.255.255");
		wait_drained();

		strings = 0;
		sent_chars = 0;
		while (sent_chars < RandomChars) begin
			if ($urandom_range(0, 7) == 0) quiet = !quiet;
			build_text();
			send_queue();
			strings++;
			if (strings % 12 == 0) wait_drained();
		end

		wait_drained();
		repeat (5) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("tb_ipv4_dotted_address_parser_core: clean");
		end else begin
			$display("tb_ipv4_dotted_address_parser_core: errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/ipv4p_pkg.sv
sv/ipv4_dotted_address_parser_core.sv
sv/ipv4p_checker.sv
tb/tb_ipv4_dotted_address_parser_core.sv
